[rtl/lmrs_pkg.sv]
// Shared constants and types for the LED matrix row-scan PWM driver.
package lmrs_pkg;

  localparam int unsigned ROWS_DEF       = 8;
  localparam int unsigned COLS_DEF       = 8;
  localparam int unsigned LEVEL_BITS_DEF = 16;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [15:0] ROW_PERIOD_RST = 16'd43749;
  localparam logic [15:0] PWM_TOP_RST    = 16'hffff;
  localparam logic        ACTIVE_LOW_RST = 1'b1;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_WRITE = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_PERIOD = 2'd0,
    REG_PWM_TOP    = 2'd1,
    REG_ACTIVE_LOW = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic        en;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [15:0] level;
  } wr_req_t;

endpackage

[rtl/lmrs_frame.sv]
// Frame store: one level per pixel, organized by row, whole-row read port.
module lmrs_frame #(
  parameter int unsigned ROWS       = lmrs_pkg::ROWS_DEF,
  parameter int unsigned COLS       = lmrs_pkg::COLS_DEF,
  parameter int unsigned LEVEL_BITS = lmrs_pkg::LEVEL_BITS_DEF,
  localparam int unsigned RW = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int unsigned CW = (COLS > 1) ? $clog2(COLS) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lmrs_pkg::wr_req_t                  wr_i,
  input  logic [RW-1:0]                      rd_row_i,
  output logic [COLS-1:0][LEVEL_BITS-1:0]    rd_data_o
);

  logic [COLS-1:0][LEVEL_BITS-1:0] frame_q [ROWS];
  logic [7:0]    row8;
  logic [7:0]    col8;
  logic          hit;
  logic [RW-1:0] wr_row;
  logic [CW-1:0] wr_col;

  assign row8   = {5'b0, wr_i.row};
  assign col8   = {5'b0, wr_i.col};
  assign hit    = wr_i.en && (row8 < 8'(ROWS)) && (col8 < 8'(COLS));
  assign wr_row = row8[RW-1:0];
  assign wr_col = col8[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        frame_q[r] <= '0;
      end
    end else if (hit) begin
      frame_q[wr_row][wr_col] <= wr_i.level[LEVEL_BITS-1:0];
    end
  end

  assign rd_data_o = frame_q[rd_row_i];

endmodule

[rtl/led_matrix_row_scan_pwm_top.sv]
// Top level of the LED matrix row-scan PWM driver.
//
// Input channel (in_valid_i/in_ready_o) carries one item per handshake: a tick
// (action 0) or a pixel write (action 1, pixel_row/pixel_col/pixel_level).
// Every item yields exactly one result on the output channel
// (out_valid_o/out_ready_i): column pin levels, one-hot row select, row number
// and a flag set when the tick moved the scan to the next row.
// An item waits in the input register until the output register is free or is
// being taken; then counters, frame store and column duties are updated, and its
// result is loaded into the output register at the same edge, raising out_valid_o.
// Throughput is one item per cycle while the receiver takes each result, set by
// the single input/output register pair.
// When the receiver stalls the result holds; the input register still takes one
// more item, after which in_ready_o drops until the output is taken.
// Reset clears the frame store (all levels zero), column duties, row, scan and
// PWM counters, and loads row_period 43749, pwm_top 65535, active_low 1.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 row
// period, 1 PWM top, 2 active-low select) at once; write only while idle.
module led_matrix_row_scan_pwm_top #(
  parameter int unsigned ROWS       = lmrs_pkg::ROWS_DEF,
  parameter int unsigned COLS       = lmrs_pkg::COLS_DEF,
  parameter int unsigned LEVEL_BITS = lmrs_pkg::LEVEL_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lmrs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lmrs_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic [2:0]                     pixel_row_i,
  input  logic [2:0]                     pixel_col_i,
  input  logic [15:0]                    pixel_level_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     column_drive_o,
  output logic [7:0]                     row_select_o,
  output logic [2:0]                     row_index_o,
  output logic                           row_changed_o
);

  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned NPIN = (COLS < 8) ? COLS : 8;

  // configuration
  logic [15:0] row_period_q;
  logic [15:0] pwm_top_q;
  logic        active_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_period_q <= lmrs_pkg::ROW_PERIOD_RST;
      pwm_top_q    <= lmrs_pkg::PWM_TOP_RST;
      active_low_q <= lmrs_pkg::ACTIVE_LOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lmrs_pkg::REG_ROW_PERIOD: row_period_q <= cfg_wdata_i[15:0];
        lmrs_pkg::REG_PWM_TOP:    pwm_top_q    <= cfg_wdata_i[15:0];
        lmrs_pkg::REG_ACTIVE_LOW: active_low_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input register
  logic                in_vld_q;
  lmrs_pkg::action_e   act_q;
  logic [2:0]          prow_q;
  logic [2:0]          pcol_q;
  logic [15:0]         plvl_q;
  logic                advance;

  assign advance    = in_vld_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q  <= lmrs_pkg::action_e'(action_i);
      prow_q <= pixel_row_i;
      pcol_q <= pixel_col_i;
      plvl_q <= pixel_level_i;
    end
  end

  // scan state
  logic [RW-1:0]                   row_q, row_d, row_nxt;
  logic [15:0]                     scan_q, scan_d, scan_inc;
  logic [15:0]                     pwm_q, pwm_d;
  logic [COLS-1:0][LEVEL_BITS-1:0] duty_q, duty_d;
  logic [COLS-1:0][LEVEL_BITS-1:0] rd_data;
  logic                            tick;
  logic                            latch;
  lmrs_pkg::wr_req_t               wr_req;

  assign tick     = advance && (act_q == lmrs_pkg::ACT_TICK);
  assign scan_inc = scan_q + 16'd1;
  assign latch    = tick && (scan_inc >= row_period_q);
  assign row_nxt  = (row_q == RW'(ROWS - 1)) ? '0 : row_q + RW'(1);

  assign wr_req.en    = advance && (act_q == lmrs_pkg::ACT_WRITE);
  assign wr_req.row   = prow_q;
  assign wr_req.col   = pcol_q;
  assign wr_req.level = plvl_q;

  lmrs_frame #(
    .ROWS       (ROWS),
    .COLS       (COLS),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr_req),
    .rd_row_i  (row_nxt),
    .rd_data_o (rd_data)
  );

  always_comb begin
    row_d  = row_q;
    scan_d = scan_q;
    pwm_d  = pwm_q;
    duty_d = duty_q;
    if (latch) begin
      row_d  = row_nxt;
      scan_d = '0;
      pwm_d  = '0;
      duty_d = rd_data;
    end else if (tick) begin
      scan_d = scan_inc;
      pwm_d  = (pwm_q >= pwm_top_q) ? 16'd0 : pwm_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      scan_q <= '0;
      pwm_q  <= '0;
      duty_q <= '0;
    end else begin
      row_q  <= row_d;
      scan_q <= scan_d;
      pwm_q  <= pwm_d;
      duty_q <= duty_d;
    end
  end

  // result
  logic [7:0] pins_d;
  logic [7:0] sel_d;
  logic [7:0] row8_d;

  always_comb begin
    pins_d = '0;
    for (int c = 0; c < NPIN; c++) begin
      pins_d[c] = (pwm_d < 16'(duty_d[c])) ^ active_low_q;
    end
    sel_d = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < ROWS) begin
        sel_d[i] = (row_d == RW'(i));
      end
    end
    row8_d = 8'(row_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      column_drive_o <= pins_d;
      row_select_o   <= sel_d;
      row_index_o    <= row8_d[2:0];
      row_changed_o  <= latch;
    end
  end

`ifndef ASSERT_OFF
  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(row_select_o))
    else $error("row select not one-hot");

  a_latch_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch |=> (scan_q == 16'd0) && (pwm_q == 16'd0))
    else $error("counters not cleared on row change");

  a_write_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_req.en |=> $stable(scan_q) && $stable(pwm_q) && $stable(row_q))
    else $error("write item moved the scan");

  a_changed_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch |=> row_q == $past(row_nxt))
    else $error("row did not advance on row change");
`endif

endmodule
